>>> design/triangle_unit_normal_assert.svh
// Assertion macros shared by the unit-normal block.
`ifndef TRIANGLE_UNIT_NORMAL_ASSERT_SVH
`define TRIANGLE_UNIT_NORMAL_ASSERT_SVH
// Property that must hold at every clock edge outside reset.
`define TUN_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Property that must hold at every clock edge, reset included.
`define TUN_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

>>> design/tun_pkg.sv
// ----------------------------------------------------------------------------
// tun_pkg
// Shared types and fixed widths for the triangle unit-normal pipeline.
// ----------------------------------------------------------------------------
package tun_pkg;
    localparam int OUT_BITS = 16;

    // Flow control seen by every pipeline stage.
    typedef struct packed {
        logic advance;
        logic flush;
    } t_ctl;
endpackage

>>> design/triangle_unit_normal.sv
// Triangle unit normal: one triangle enters per cycle while the output is not
// stalled, and its normal leaves the output register as a Q1.14 value. Five
// front stages form the sum of squares, then come 2*COORD_BITS+3 square root
// stages, 2*COORD_BITS+2+NORMAL_FRAC_BITS divide stages and the output register.
// A stall on the output freezes the whole pipeline; o_stall is raised in every
// cycle in which the output holds an item and i_stall is high.
// ----------------------------------------------------------------------------
// triangle_unit_normal
// Edges, cross product, sum of squares, square root and three divides.
// ----------------------------------------------------------------------------
`include "triangle_unit_normal_assert.svh"
module triangle_unit_normal #(
    parameter int COORD_BITS       = 12,
    parameter int NORMAL_FRAC_BITS = 14
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [COORD_BITS-1:0] i_vertex_a_x,
    input  logic [COORD_BITS-1:0] i_vertex_a_y,
    input  logic [COORD_BITS-1:0] i_vertex_a_z,
    input  logic [COORD_BITS-1:0] i_vertex_b_x,
    input  logic [COORD_BITS-1:0] i_vertex_b_y,
    input  logic [COORD_BITS-1:0] i_vertex_b_z,
    input  logic [COORD_BITS-1:0] i_vertex_c_x,
    input  logic [COORD_BITS-1:0] i_vertex_c_y,
    input  logic [COORD_BITS-1:0] i_vertex_c_z,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [tun_pkg::OUT_BITS-1:0] o_normal_x,
    output logic [tun_pkg::OUT_BITS-1:0] o_normal_y,
    output logic [tun_pkg::OUT_BITS-1:0] o_normal_z,
    output logic                  o_degenerate
);
    localparam int EW  = COORD_BITS + 1;          // edge
    localparam int PW  = 2 * EW;                  // product
    localparam int CW  = PW + 1;                  // cross component (signed)
    localparam int MW  = CW - 1;                  // magnitude
    localparam int QW  = 2 * MW;                  // square
    localparam int SW0 = QW + 2;                  // sum of three squares
    localparam int SW  = SW0 + (SW0 % 2);         // even for the root
    localparam int RW  = SW / 2;
    localparam int NW  = MW + NORMAL_FRAC_BITS;   // dividend
    localparam int OB  = tun_pkg::OUT_BITS;
    localparam int TW  = 3 * (MW + 1) + 2;        // tag: signs, mags, deg, valid
    localparam int DLY = RW;

    tun_pkg::t_ctl ctl;

    // Whole pipeline moves together; hold while the output item waits.
    assign ctl.advance = !(o_valid && i_stall);
    assign ctl.flush   = !i_rst_n;
    assign o_stall     = !ctl.advance;

    // Stage 1: edges.
    logic            r_v1;
    logic [EW-1:0]   r_e1x, r_e1y, r_e1z, r_e2x, r_e2y, r_e2z;
    always_ff @(posedge i_clk) begin
        if (ctl.flush) begin
            r_v1 <= 1'b0;
        end else if (ctl.advance) begin
            r_v1 <= i_valid;
        end
        if (ctl.advance) begin
            r_e1x <= EW'(signed'(i_vertex_c_x)) - EW'(signed'(i_vertex_a_x));
            r_e1y <= EW'(signed'(i_vertex_c_y)) - EW'(signed'(i_vertex_a_y));
            r_e1z <= EW'(signed'(i_vertex_c_z)) - EW'(signed'(i_vertex_a_z));
            r_e2x <= EW'(signed'(i_vertex_b_x)) - EW'(signed'(i_vertex_a_x));
            r_e2y <= EW'(signed'(i_vertex_b_y)) - EW'(signed'(i_vertex_a_y));
            r_e2z <= EW'(signed'(i_vertex_b_z)) - EW'(signed'(i_vertex_a_z));
        end
    end

    // Stage 2: six products.
    logic          r_v2;
    logic [PW-1:0] r_p0, r_p1, r_p2, r_p3, r_p4, r_p5;
    always_ff @(posedge i_clk) begin
        if (ctl.flush) begin
            r_v2 <= 1'b0;
        end else if (ctl.advance) begin
            r_v2 <= r_v1;
        end
        if (ctl.advance) begin
            r_p0 <= PW'(signed'(r_e1y) * signed'(r_e2z));
            r_p1 <= PW'(signed'(r_e1z) * signed'(r_e2y));
            r_p2 <= PW'(signed'(r_e1z) * signed'(r_e2x));
            r_p3 <= PW'(signed'(r_e1x) * signed'(r_e2z));
            r_p4 <= PW'(signed'(r_e1x) * signed'(r_e2y));
            r_p5 <= PW'(signed'(r_e1y) * signed'(r_e2x));
        end
    end

    // Stage 3: cross product as sign and magnitude.
    logic          r_v3;
    logic [2:0]    r_sg3;
    logic [MW-1:0] r_m3x, r_m3y, r_m3z;
    logic [CW-1:0] n_cx, n_cy, n_cz;
    always_comb begin
        n_cx = CW'(signed'(r_p0)) - CW'(signed'(r_p1));
        n_cy = CW'(signed'(r_p2)) - CW'(signed'(r_p3));
        n_cz = CW'(signed'(r_p4)) - CW'(signed'(r_p5));
    end
    always_ff @(posedge i_clk) begin
        if (ctl.flush) begin
            r_v3 <= 1'b0;
        end else if (ctl.advance) begin
            r_v3 <= r_v2;
        end
        if (ctl.advance) begin
            r_sg3 <= {n_cz[CW-1], n_cy[CW-1], n_cx[CW-1]};
            r_m3x <= n_cx[CW-1] ? MW'(-n_cx) : n_cx[MW-1:0];
            r_m3y <= n_cy[CW-1] ? MW'(-n_cy) : n_cy[MW-1:0];
            r_m3z <= n_cz[CW-1] ? MW'(-n_cz) : n_cz[MW-1:0];
        end
    end

    // Stage 4: squares.
    logic          r_v4;
    logic [2:0]    r_sg4;
    logic [MW-1:0] r_m4x, r_m4y, r_m4z;
    logic [QW-1:0] r_qx, r_qy, r_qz;
    always_ff @(posedge i_clk) begin
        if (ctl.flush) begin
            r_v4 <= 1'b0;
        end else if (ctl.advance) begin
            r_v4 <= r_v3;
        end
        if (ctl.advance) begin
            r_sg4 <= r_sg3;
            r_m4x <= r_m3x;
            r_m4y <= r_m3y;
            r_m4z <= r_m3z;
            r_qx  <= QW'(r_m3x * r_m3x);
            r_qy  <= QW'(r_m3y * r_m3y);
            r_qz  <= QW'(r_m3z * r_m3z);
        end
    end

    // Stage 5: sum of squares and degenerate detect.
    logic          r_v5;
    logic [2:0]    r_sg5;
    logic [MW-1:0] r_m5x, r_m5y, r_m5z;
    logic [SW-1:0] r_s5;
    always_ff @(posedge i_clk) begin
        if (ctl.flush) begin
            r_v5 <= 1'b0;
        end else if (ctl.advance) begin
            r_v5 <= r_v4;
        end
        if (ctl.advance) begin
            r_sg5 <= r_sg4;
            r_m5x <= r_m4x;
            r_m5y <= r_m4y;
            r_m5z <= r_m4z;
            r_s5  <= SW'(r_qx) + SW'(r_qy) + SW'(r_qz);
        end
    end

    // Square root; signs, magnitudes and valid ride along as the tag.
    logic [TW-1:0] sq_tag_in, sq_tag_out;
    logic [RW-1:0] root;
    logic          deg5;
    assign deg5      = (r_s5 == '0);
    assign sq_tag_in = {r_v5, deg5, r_sg5[2], r_m5z, r_sg5[1], r_m5y, r_sg5[0], r_m5x};

    tun_isqrt #(.SW(SW), .RW(RW), .TW(TW)) u_isqrt (
        .i_clk  (i_clk),
        .i_en   (ctl.advance),
        .i_sq   (r_s5),
        .i_tag  (sq_tag_in),
        .o_root (root),
        .o_tag  (sq_tag_out)
    );

    // The root stages carry valid in the tag; clear it with reset via a shadow.
    logic [DLY-1:0] r_vsh;
    always_ff @(posedge i_clk) begin
        if (ctl.flush) begin
            r_vsh <= '0;
        end else if (ctl.advance) begin
            r_vsh <= {r_vsh[DLY-2:0], r_v5};
        end
    end

    logic [MW-1:0] sx, sy, sz;
    logic          snx, sny, snz, sdeg;
    assign {sdeg, snz, sz, sny, sy, snx, sx} = sq_tag_out[TW-2:0];

    // Degenerate items divide by one; their output is forced to zero.
    logic [RW-1:0] den;
    assign den = sdeg ? RW'(1) : root;

    localparam int DTW = 4;
    logic [DTW-1:0] dtag_in, dtag_x, dtag_y, dtag_z;
    logic [NW-1:0]  qx, qy, qz;
    assign dtag_in = {1'b0, sdeg, 1'b0, 1'b0};

    tun_div #(.NW(NW), .DW(RW), .TW(DTW)) u_div_x (
        .i_clk(i_clk), .i_en(ctl.advance),
        .i_num({sx, NORMAL_FRAC_BITS'(0)}), .i_den(den),
        .i_tag({snx, sdeg, 2'b00}), .o_quo(qx), .o_tag(dtag_x)
    );
    tun_div #(.NW(NW), .DW(RW), .TW(DTW)) u_div_y (
        .i_clk(i_clk), .i_en(ctl.advance),
        .i_num({sy, NORMAL_FRAC_BITS'(0)}), .i_den(den),
        .i_tag({sny, dtag_in[2:0]}), .o_quo(qy), .o_tag(dtag_y)
    );
    tun_div #(.NW(NW), .DW(RW), .TW(DTW)) u_div_z (
        .i_clk(i_clk), .i_en(ctl.advance),
        .i_num({sz, NORMAL_FRAC_BITS'(0)}), .i_den(den),
        .i_tag({snz, dtag_in[2:0]}), .o_quo(qz), .o_tag(dtag_z)
    );

    logic [NW-1:0] r_vdv;
    always_ff @(posedge i_clk) begin
        if (ctl.flush) begin
            r_vdv <= '0;
        end else if (ctl.advance) begin
            r_vdv <= {r_vdv[NW-2:0], r_vsh[DLY-1]};
        end
    end

    // Output register: apply signs, zero degenerate items, wrap to the output width.
    logic          r_ov;
    logic [OB-1:0] r_nx, r_ny, r_nz;
    logic          r_deg;
    always_ff @(posedge i_clk) begin
        if (ctl.flush) begin
            r_ov <= 1'b0;
        end else if (ctl.advance) begin
            r_ov <= r_vdv[NW-1];
        end
        if (ctl.advance) begin
            r_deg <= dtag_x[2];
            r_nx  <= dtag_x[2] ? '0 : (dtag_x[3] ? OB'(-qx) : OB'(qx));
            r_ny  <= dtag_x[2] ? '0 : (dtag_y[3] ? OB'(-qy) : OB'(qy));
            r_nz  <= dtag_x[2] ? '0 : (dtag_z[3] ? OB'(-qz) : OB'(qz));
        end
    end

    assign o_valid      = r_ov;
    assign o_normal_x   = r_nx;
    assign o_normal_y   = r_ny;
    assign o_normal_z   = r_nz;
    assign o_degenerate = r_deg;

    logic unused_ok;
    assign unused_ok = ^{sq_tag_out[TW-1], dtag_x[1:0], dtag_y[2:0], dtag_z[2:0],
                         dtag_in[3]};

    `TUN_ASSERT(a_hold_out, i_clk, i_rst_n, (o_valid && i_stall) |=> o_valid,
                "output item lost under stall")
    `TUN_ASSERT(a_hold_val, i_clk, i_rst_n, (o_valid && i_stall) |=> $stable(o_normal_x),
                "stalled output changed")
    `TUN_ASSERT(a_deg_zero, i_clk, i_rst_n, (o_valid && o_degenerate) |->
                (o_normal_x == '0 && o_normal_y == '0 && o_normal_z == '0),
                "degenerate item not zero")
    `TUN_ASSERT_ALWAYS(a_rst_clr, i_clk, !i_rst_n |=> !o_valid, "valid after reset")
endmodule

>>> design/tun_isqrt.sv
// ----------------------------------------------------------------------------
// tun_isqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module tun_isqrt #(
    parameter int SW = 72,
    parameter int RW = 36,
    parameter int TW = 8
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [SW-1:0] i_sq,
    input  logic [TW-1:0] i_tag,
    output logic [RW-1:0] o_root,
    output logic [TW-1:0] o_tag
);
    // Restoring style: remainder and root carried through RW stages.
    localparam int REMW = RW + 2;

    logic [SW-1:0]   r_sq   [RW+1];
    logic [REMW-1:0] r_rem  [RW+1];
    logic [RW-1:0]   r_root [RW+1];
    logic [TW-1:0]   r_tag  [RW+1];

    always_comb begin
        r_sq[0]   = i_sq;
        r_rem[0]  = '0;
        r_root[0] = '0;
        r_tag[0]  = i_tag;
    end

    for (genvar g = 0; g < RW; g++) begin : g_st
        logic [REMW-1:0] n_rem_sh;
        logic [REMW-1:0] n_trial;
        logic [REMW:0]   n_diff;
        always_comb begin
            n_rem_sh = {r_rem[g][REMW-3:0], r_sq[g][SW-1 -: 2]};
            n_trial  = {r_root[g][RW-1:0], 2'b01};
            n_diff   = {1'b0, n_rem_sh} - {1'b0, n_trial};
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sq[g+1]  <= {r_sq[g][SW-3:0], 2'b00};
                r_tag[g+1] <= r_tag[g];
                if (!n_diff[REMW]) begin
                    r_rem[g+1]  <= n_diff[REMW-1:0];
                    r_root[g+1] <= {r_root[g][RW-2:0], 1'b1};
                end else begin
                    r_rem[g+1]  <= n_rem_sh;
                    r_root[g+1] <= {r_root[g][RW-2:0], 1'b0};
                end
            end
        end
    end

    assign o_root = r_root[RW];
    assign o_tag  = r_tag[RW];
endmodule

>>> design/tun_div.sv
// ----------------------------------------------------------------------------
// tun_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module tun_div #(
    parameter int NW = 50,
    parameter int DW = 36,
    parameter int TW = 8
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [TW-1:0] i_tag,
    output logic [NW-1:0] o_quo,
    output logic [TW-1:0] o_tag
);
    logic [NW-1:0] r_num [NW+1];
    logic [DW-1:0] r_den [NW+1];
    logic [DW:0]   r_rem [NW+1];
    logic [NW-1:0] r_quo [NW+1];
    logic [TW-1:0] r_tag [NW+1];

    always_comb begin
        r_num[0] = i_num;
        r_den[0] = i_den;
        r_rem[0] = '0;
        r_quo[0] = '0;
        r_tag[0] = i_tag;
    end

    for (genvar g = 0; g < NW; g++) begin : g_st
        logic [DW+1:0] n_sh;
        logic [DW+1:0] n_diff;
        always_comb begin
            n_sh   = {r_rem[g], r_num[g][NW-1]};
            n_diff = n_sh - {2'b00, r_den[g]};
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num[g+1] <= {r_num[g][NW-2:0], 1'b0};
                r_den[g+1] <= r_den[g];
                r_tag[g+1] <= r_tag[g];
                if (!n_diff[DW+1]) begin
                    r_rem[g+1] <= n_diff[DW:0];
                    r_quo[g+1] <= {r_quo[g][NW-2:0], 1'b1};
                end else begin
                    r_rem[g+1] <= n_sh[DW:0];
                    r_quo[g+1] <= {r_quo[g][NW-2:0], 1'b0};
                end
            end
        end
    end

    assign o_quo = r_quo[NW];
    assign o_tag = r_tag[NW];
endmodule
